>>> src/ssae_pkg.sv
// ----------------------------------------------------------------------------
// Sprite sheet animation engine package
// Shared slot counts, operation and status codes.
// ----------------------------------------------------------------------------
`default_nettype none
package ssae_pkg;
  localparam int unsigned PatternSlots = 256;
  localparam int unsigned PlayerSlots  = 256;

  localparam logic [2:0] OpRegister = 3'd0;
  localparam logic [2:0] OpCreate   = 3'd1;
  localparam logic [2:0] OpDestroy  = 3'd2;
  localparam logic [2:0] OpTick     = 3'd3;
  localparam logic [2:0] OpDraw     = 3'd4;
  localparam logic [2:0] OpStopped  = 3'd5;

  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StNoFree = 2'd1;
  localparam logic [1:0] StNotUse = 2'd2;
endpackage
`default_nettype wire

>>> src/ssae_divider.sv
// ----------------------------------------------------------------------------
// Frame divider
// Restoring divider: frame / per_row, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module ssae_divider (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [11:0] dividend_i,
  input  wire logic [11:0] divisor_i,
  output logic             done_o,
  output logic [11:0]      quot_o,
  output logic [11:0]      rem_o
);
  logic [11:0] quot_q, quot_d, div_q, div_d;
  logic [12:0] rem_q, rem_d, trial;
  logic [3:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[11:0], quot_q[11]};
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
      cnt_d  = 4'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d  = trial - {1'b0, div_q};
        quot_d = {quot_q[10:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[10:0], 1'b0};
      end
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == 4'd11) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q[11:0];
endmodule
`default_nettype wire

>>> src/sprite_sheet_animation_engine_top.sv
// ----------------------------------------------------------------------------
// Sprite sheet animation engine
// Pattern and player tables in synchronous memories, one sequencer.
// Register and create scan for a free slot; tick reads the player, reads the pattern,
// then updates and writes each player in turn; draw runs the 12-step divider and a
// multiply stage; the stopped query reads the player record.
// One transaction at a time; busy is high meanwhile.
// The receiver cannot stall; done_o strobes one cycle per transaction.
// Reset clears all valid and active bits at once; create clears the stopped bit.
// ----------------------------------------------------------------------------
`default_nettype none
module sprite_sheet_animation_engine_top #(
  parameter int unsigned PATTERN_SLOTS = ssae_pkg::PatternSlots,
  parameter int unsigned PLAYER_SLOTS  = ssae_pkg::PlayerSlots
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  output logic             done_o,
  input  wire logic [2:0]  op_i,
  input  wire logic [7:0]  slot_i,
  input  wire logic [15:0] tex_id_i,
  input  wire logic [11:0] frame_count_i,
  input  wire logic [11:0] frames_per_row_i,
  input  wire logic [31:0] time_value_i,
  input  wire logic [15:0] frame_width_i,
  input  wire logic [15:0] frame_height_i,
  input  wire logic [15:0] start_x_i,
  input  wire logic [15:0] start_y_i,
  input  wire logic        looped_i,
  output logic [1:0]       status_o,
  output logic [7:0]       handle_o,
  output logic [15:0]      tex_out_o,
  output logic [31:0]      src_x_o,
  output logic [31:0]      src_y_o,
  output logic [15:0]      src_w_o,
  output logic [15:0]      src_h_o,
  output logic             stopped_o
);
  localparam int unsigned PaW = (PATTERN_SLOTS > 1) ? $clog2(PATTERN_SLOTS) : 1;
  localparam int unsigned PlW = (PLAYER_SLOTS > 1) ? $clog2(PLAYER_SLOTS) : 1;
  localparam int unsigned PaCw = $clog2(PATTERN_SLOTS + 1);
  localparam int unsigned PlCw = $clog2(PLAYER_SLOTS + 1);
  localparam int unsigned CW = (PaCw > PlCw) ? PaCw : PlCw;

  localparam logic [3:0] SIdle = 4'd0, SScan = 4'd1, STickRd = 4'd2,
    STickPa = 4'd3, STickWr = 4'd4, SQRd = 4'd5, SQPa = 4'd6, SDiv = 4'd7,
    SDivW = 4'd8, SMul = 4'd9, SOut = 4'd10;

  // memories
  logic [40:0] pa_frames_mem [PATTERN_SLOTS];
  logic [31:0] pa_period_mem [PATTERN_SLOTS];
  logic [63:0] pa_geom_mem   [PATTERN_SLOTS];
  logic [52:0] pl_mem        [PLAYER_SLOTS]; // {stop1, pattern8, frame12, time32}
  logic [PATTERN_SLOTS-1:0] pa_valid_q;
  logic [PLAYER_SLOTS-1:0]  pl_active_q;

  logic [3:0]  st_q;
  logic [2:0]  op_q;
  logic [7:0]  slot_q;
  logic [15:0] tex_q, fw_q, fh_q, sx_q, sy_q;
  logic [11:0] fc_q, fpr_q;
  logic [31:0] tv_q;
  logic        lp_q;
  logic [CW-1:0] idx_q;
  logic [1:0]  r_status_q;
  logic [7:0]  r_handle_q;
  logic [15:0] r_tex_q, r_w_q, r_h_q;
  logic [31:0] r_x_q, r_y_q;
  logic        r_stop_q, done_q;

  logic [40:0] pa_f_rd;
  logic [31:0] pa_p_rd;
  logic [63:0] pa_g_rd;
  logic [52:0] pl_rd;
  logic [PaW-1:0] pa_ra;
  logic [PlW-1:0] pl_ra;
  logic        pl_we;
  logic [PlW-1:0] pl_wa;
  logic [52:0] pl_wd;
  logic [52:0] pl_hold_q;
  logic [40:0] f_hold_q;
  logic [63:0] g_hold_q;
  logic [11:0] col_q, row_q;

  logic        div_start, div_done;
  logic [11:0] div_quot, div_rem;

  ssae_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start),
    .dividend_i(pl_hold_q[43:32]), .divisor_i(pa_f_rd[12:1]),
    .done_o(div_done), .quot_o(div_quot), .rem_o(div_rem)
  );

  logic idx_pa_ok, idx_pl_ok;
  assign idx_pa_ok  = idx_q < CW'(PATTERN_SLOTS);
  assign idx_pl_ok  = idx_q < CW'(PLAYER_SLOTS);

  // tick update
  logic [11:0] cnt_eff, nxt;
  logic [12:0] inc;
  logic [31:0] t_cur, t_sub;
  logic [32:0] sum;
  logic        adv, stop_set;
  always_comb begin
    cnt_eff  = (pa_f_rd[24:13] == 12'd0) ? 12'd1 : pa_f_rd[24:13];
    t_cur    = pl_hold_q[31:0];
    adv      = t_cur >= pa_p_rd;
    inc      = {1'b0, pl_hold_q[43:32]} + 13'd1;
    nxt      = inc[11:0];
    stop_set = 1'b0;
    if (inc >= {1'b0, cnt_eff}) begin
      if (pa_f_rd[0]) nxt = 12'd0;
      else begin
        nxt      = cnt_eff - 12'd1;
        stop_set = adv;
      end
    end
    if (!adv) nxt = pl_hold_q[43:32];
    t_sub = adv ? t_cur - pa_p_rd : t_cur;
    sum   = {1'b0, t_sub} + {1'b0, tv_q};
  end

  always_ff @(posedge clk_i) begin
    pa_f_rd <= pa_frames_mem[pa_ra];
    pa_p_rd <= pa_period_mem[pa_ra];
    pa_g_rd <= pa_geom_mem[pa_ra];
    pl_rd   <= pl_mem[pl_ra];
    if (pl_we) pl_mem[pl_wa] <= pl_wd;
    if (st_q == SScan && op_q == ssae_pkg::OpRegister && idx_pa_ok
        && !pa_valid_q[idx_q[PaW-1:0]]) begin
      pa_frames_mem[idx_q[PaW-1:0]] <= {tex_q, fc_q, fpr_q, lp_q};
      pa_period_mem[idx_q[PaW-1:0]] <= tv_q;
      pa_geom_mem[idx_q[PaW-1:0]]   <= {fw_q, fh_q, sx_q, sy_q};
    end
  end

  always_comb begin
    pa_ra = (st_q == STickPa || st_q == SQPa) ? PaW'(pl_rd[51:44]) : PaW'(slot_q);
    pl_ra = (st_q == SIdle || st_q == SScan || st_q == SQRd) ? PlW'(slot_q)
          : idx_q[PlW-1:0];
    pl_we = 1'b0;
    pl_wa = idx_q[PlW-1:0];
    pl_wd = {1'b0, slot_q, 12'd0, 32'd0};
    if (st_q == SScan && op_q == ssae_pkg::OpCreate && idx_pl_ok
        && !pl_active_q[idx_q[PlW-1:0]]) pl_we = 1'b1;
    if (st_q == STickWr && idx_pl_ok && pl_active_q[idx_q[PlW-1:0]]) begin
      pl_we = 1'b1;
      pl_wd = {pl_hold_q[52] | stop_set, pl_hold_q[51:44], nxt,
               sum[32] ? 32'hFFFF_FFFF : sum[31:0]};
    end
  end

  assign div_start = st_q == SDiv;

  always_ff @(posedge clk_i) begin
    if (st_q == STickPa || st_q == SQPa) pl_hold_q <= pl_rd;
    if (st_q == SDiv) begin
      f_hold_q <= pa_f_rd;
      g_hold_q <= pa_g_rd;
    end
    if (st_q == SDivW && div_done) begin
      col_q <= div_rem;
      row_q <= div_quot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      pa_valid_q <= '0;
      pl_active_q <= '0;
      done_q <= 1'b0;
      idx_q <= '0;
    end else begin
      done_q <= 1'b0;
      case (st_q)
        SIdle: if (start) begin
          op_q <= op_i; slot_q <= slot_i; tex_q <= tex_id_i; fc_q <= frame_count_i;
          fpr_q <= frames_per_row_i; tv_q <= time_value_i; fw_q <= frame_width_i;
          fh_q <= frame_height_i; sx_q <= start_x_i; sy_q <= start_y_i;
          lp_q <= looped_i; idx_q <= '0;
          r_status_q <= ssae_pkg::StOk; r_handle_q <= '0; r_tex_q <= '0;
          r_x_q <= '0; r_y_q <= '0; r_w_q <= '0; r_h_q <= '0; r_stop_q <= 1'b0;
          case (op_i)
            ssae_pkg::OpRegister: st_q <= SScan;
            ssae_pkg::OpCreate: begin
              if (32'(slot_i) >= PATTERN_SLOTS || !pa_valid_q[PaW'(slot_i)]) begin
                r_status_q <= ssae_pkg::StNotUse;
                st_q <= SOut;
              end else st_q <= SScan;
            end
            ssae_pkg::OpTick: st_q <= STickRd;
            ssae_pkg::OpDestroy, ssae_pkg::OpDraw, ssae_pkg::OpStopped: begin
              if (32'(slot_i) >= PLAYER_SLOTS || !pl_active_q[PlW'(slot_i)]) begin
                r_status_q <= ssae_pkg::StNotUse;
                st_q <= SOut;
              end else if (op_i == ssae_pkg::OpDestroy) begin
                pl_active_q[PlW'(slot_i)] <= 1'b0;
                st_q <= SOut;
              end else st_q <= SQRd;
            end
            default: st_q <= SOut;
          endcase
        end
        SScan: begin
          if (op_q == ssae_pkg::OpRegister) begin
            if (!idx_pa_ok) begin
              r_status_q <= ssae_pkg::StNoFree; st_q <= SOut;
            end else if (!pa_valid_q[idx_q[PaW-1:0]]) begin
              pa_valid_q[idx_q[PaW-1:0]] <= 1'b1;
              r_handle_q <= 8'(idx_q); st_q <= SOut;
            end else idx_q <= idx_q + CW'(1);
          end else begin
            if (!idx_pl_ok) begin
              r_status_q <= ssae_pkg::StNoFree; st_q <= SOut;
            end else if (!pl_active_q[idx_q[PlW-1:0]]) begin
              pl_active_q[idx_q[PlW-1:0]] <= 1'b1;
              r_handle_q <= 8'(idx_q); st_q <= SOut;
            end else idx_q <= idx_q + CW'(1);
          end
        end
        STickRd: st_q <= idx_pl_ok ? STickPa : SOut;
        STickPa: st_q <= STickWr;
        STickWr: begin
          idx_q <= idx_q + CW'(1);
          st_q <= STickRd;
        end
        SQRd: st_q <= SQPa;
        SQPa: begin
          if (op_q == ssae_pkg::OpStopped) begin
            r_stop_q <= pl_rd[52];
            st_q <= SOut;
          end else st_q <= SDiv;
        end
        SDiv: st_q <= SDivW;
        SDivW: if (div_done) st_q <= SMul;
        SMul: begin
          r_tex_q <= f_hold_q[40:25];
          r_w_q <= g_hold_q[63:48];
          r_h_q <= g_hold_q[47:32];
          if (f_hold_q[12:1] == 12'd0) begin
            r_x_q <= 32'(g_hold_q[31:16]) + 32'(g_hold_q[63:48]) * 32'(pl_hold_q[43:32]);
            r_y_q <= 32'(g_hold_q[15:0]);
          end else begin
            r_x_q <= 32'(g_hold_q[31:16]) + 32'(g_hold_q[63:48]) * 32'(col_q);
            r_y_q <= 32'(g_hold_q[15:0]) + 32'(g_hold_q[47:32]) * 32'(row_q);
          end
          st_q <= SOut;
        end
        SOut: begin
          done_q <= 1'b1;
          st_q <= SIdle;
        end
        default: st_q <= SIdle;
      endcase
    end
  end

  assign busy      = st_q != SIdle;
  assign done_o    = done_q;
  assign status_o  = r_status_q;
  assign handle_o  = r_handle_q;
  assign tex_out_o = r_tex_q;
  assign src_x_o   = r_x_q;
  assign src_y_o   = r_y_q;
  assign src_w_o   = r_w_q;
  assign src_h_o   = r_h_q;
  assign stopped_o = r_stop_q;
endmodule
`default_nettype wire

>>> src/ssae_checker.sv
// ----------------------------------------------------------------------------
// Sprite sheet animation engine port checker
// Observes the top level ports only.
// ----------------------------------------------------------------------------
`default_nettype none
module ssae_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       done_o,
  input wire logic [1:0] status_o,
  input wire logic [7:0] handle_o,
  input wire logic [31:0] src_x_o
);
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("accepted transaction did not raise busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held two cycles");
  a_done_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("done while busy");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != ssae_pkg::StOk |-> handle_o == 8'd0 && src_x_o == 32'd0)
    else $error("error result carries payload");
endmodule

bind sprite_sheet_animation_engine_top ssae_checker u_ssae_checker (
  .clk_i, .rst_ni, .start, .busy, .done_o, .status_o, .handle_o, .src_x_o
);
`default_nettype wire
